// ===== rtl/tcwd_pkg.sv =====
`timescale 1ns / 1ps

package tcwd_pkg;

	// default sizing
	localparam int NUM_WORKERS_DEF = 8;
	localparam int COUNT_BITS_DEF  = 32;

	// fixed field widths
	localparam int TID_W    = 32;
	localparam int CURSOR_W = 32;
	localparam int WSEL_W   = 4;
	localparam int CFG_W    = 4;

	// item kinds
	localparam logic [1:0] KIND_SCHED = 2'd0;
	localparam logic [1:0] KIND_TAKE  = 2'd1;
	localparam logic [1:0] KIND_BIND  = 2'd2;

	// result status codes
	localparam logic [1:0] STAT_DISPATCHED = 2'd0;
	localparam logic [1:0] STAT_DEFERRED   = 2'd1;
	localparam logic [1:0] STAT_ACKED      = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_WORKER_COUNT = 2'd0;
	localparam logic [1:0] CFG_CALLER_ZERO  = 2'd1;
	localparam logic [1:0] CFG_STARTED      = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DEC,
		S_PICK,
		S_RD2,
		S_CMP,
		S_RDT,
		S_UPD,
		S_ACK
	} ctrl_state_t;

	// controller to datapath
	typedef struct packed {
		logic latch;
		logic pick;
		logic rd2;
		logic cmp;
		logic upd;
		logic ack;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic route_sched;
		logic route_take;
		logic two_pick;
	} dp_sts_t;

endpackage

// ===== rtl/tcwd_ram.sv =====
`timescale 1ns / 1ps

module tcwd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/tcwd_ctrl.sv =====
`timescale 1ns / 1ps

module tcwd_ctrl import tcwd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  dp_sts_t sts,
	output dp_cmd_t cmd,
	output logic    busy
);

	ctrl_state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.latch = 1'b1;
					state_d   = S_DEC;
				end
			end
			S_DEC: begin
				if (sts.route_sched) begin
					state_d = S_PICK;
				end else if (sts.route_take) begin
					state_d = S_RDT;
				end else begin
					state_d = S_ACK;
				end
			end
			S_PICK: begin
				cmd.pick = 1'b1;
				state_d  = sts.two_pick ? S_RD2 : S_RDT;
			end
			S_RD2: begin
				cmd.rd2 = 1'b1;
				state_d = S_CMP;
			end
			S_CMP: begin
				cmd.cmp = 1'b1;
				state_d = S_RDT;
			end
			S_RDT: begin
				state_d = S_UPD;
			end
			S_UPD: begin
				cmd.upd = 1'b1;
				state_d = S_IDLE;
			end
			S_ACK: begin
				cmd.ack = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);

endmodule

// ===== rtl/tcwd_datapath.sv =====
`timescale 1ns / 1ps

module tcwd_datapath import tcwd_pkg::*; #(
	parameter int NUM_WORKERS = NUM_WORKERS_DEF,
	parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  dp_cmd_t           cmd,
	output dp_sts_t           sts,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [CFG_W-1:0]  cfg_wdata,
	input  logic [1:0]        kind,
	input  logic signed [TID_W-1:0] thread_id,
	input  logic [2:0]        worker_sel,
	input  logic [2:0]        from_worker,
	input  logic              from_worker_valid,
	input  logic              allow_cross,
	input  logic              caller_worker_active,
	output logic              done,
	output logic [2:0]        dest_worker,
	output logic [1:0]        status,
	output logic              local_enqueue
);

	localparam int WIX    = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1;
	localparam int WC_LIM = (NUM_WORKERS < 15) ? NUM_WORKERS : 15;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	// configuration
	logic [CFG_W-1:0] wcount_q;
	logic             czero_q;
	logic             started_q;

	// latched item
	logic [1:0]       kind_q;
	logic [TID_W-1:0] tid_q;
	logic [2:0]       widx_q;
	logic [2:0]       from_q;
	logic             from_vld_q;
	logic             cross_q;
	logic             cact_q;

	// worker state
	logic [TID_W-1:0]       ids_q [NUM_WORKERS];
	logic [NUM_WORKERS-1:0] match_q;
	logic [NUM_WORKERS-1:0] cnt_vld_q;
	logic                   rd_vld_q;
	logic [CURSOR_W-1:0]    cursor_q;
	logic [WSEL_W-1:0]      res_q [2:15];

	// work registers
	logic [WSEL_W-1:0]     p1_q;
	logic [WSEL_W-1:0]     p2_q;
	logic [COUNT_BITS-1:0] cnt1_q;
	logic [WIX-1:0]        tgt_q;
	logic                  local_q;

	// combinational
	logic [WSEL_W-1:0]     wc;
	logic                  have_cur;
	logic                  found;
	logic [WSEL_W-1:0]     fidx;
	logic [WSEL_W-1:0]     from_ext;
	logic [WSEL_W-1:0]     base;
	logic [WSEL_W-1:0]     two_cnt;
	logic [WSEL_W-1:0]     res_cur;
	logic [WSEL_W-1:0]     res_inc;
	logic [WSEL_W-1:0]     r2a;
	logic [WSEL_W-1:0]     r2a_inc;
	logic [WSEL_W-1:0]     r2;
	logic [WSEL_W-1:0]     p1;
	logic [WSEL_W-1:0]     p2;
	logic                  wrap;
	logic                  two_pick;
	logic [WSEL_W-1:0]     direct_tgt;
	logic                  direct_local;
	logic [COUNT_BITS-1:0] rd_data;
	logic [COUNT_BITS-1:0] rd_eff;
	logic [WIX-1:0]        raddr;
	logic                  tie;
	logic [WSEL_W-1:0]     win;
	logic                  step;
	logic [COUNT_BITS-1:0] wr_data;
	logic                  take_ok;
	logic                  bind_ok;

	// active worker range
	always_comb begin
		if (wcount_q == '0) begin
			wc = WSEL_W'(1);
		end else if (32'(wcount_q) > WC_LIM) begin
			wc = WSEL_W'(WC_LIM);
		end else begin
			wc = wcount_q;
		end
	end

	assign from_ext = {1'b0, from_q};
	assign have_cur = from_vld_q && (from_ext < wc);
	assign take_ok  = 32'(widx_q) < NUM_WORKERS;
	assign bind_ok  = take_ok;

	// lowest matching worker
	always_comb begin
		found = 1'b0;
		fidx  = '0;
		for (int i = NUM_WORKERS - 1; i >= 0; i--) begin
			if (match_q[i]) begin
				found = 1'b1;
				fidx  = WSEL_W'(i);
			end
		end
	end

	// candidate range, skipping worker zero while it is idle
	always_comb begin
		if (czero_q && (wc > WSEL_W'(1)) && !cact_q) begin
			base    = WSEL_W'(1);
			two_cnt = wc - WSEL_W'(1);
		end else begin
			base    = '0;
			two_cnt = wc;
		end
	end

	// candidates from the cursor residues
	assign wrap    = (cursor_q == '1);
	assign res_cur = (two_cnt >= WSEL_W'(2)) ? res_q[two_cnt] : '0;
	assign res_inc = res_cur + WSEL_W'(1);
	assign r2a     = wrap ? '0 : ((res_inc == two_cnt) ? '0 : res_inc);
	assign r2a_inc = r2a + WSEL_W'(1);
	assign r2      = (r2a == res_cur) ? ((r2a_inc == two_cnt) ? '0 : r2a_inc) : r2a;
	assign p1      = base + res_cur;
	assign p2      = base + r2;
	assign two_pick = !found && !have_cur && (two_cnt > WSEL_W'(1));

	// affinity, own queue or single candidate
	always_comb begin
		direct_local = have_cur && (!found || (fidx == from_ext) || !cross_q);
		if (direct_local) begin
			direct_tgt = from_ext;
		end else if (found) begin
			direct_tgt = fidx;
		end else begin
			direct_tgt = base;
		end
	end

	// queued count store, entries not yet written read as zero
	assign raddr  = cmd.pick ? WIX'(p1) : (cmd.rd2 ? WIX'(p2_q) : tgt_q);
	assign rd_eff = rd_vld_q ? rd_data : '0;

	tcwd_ram #(
		.WIDTH (COUNT_BITS),
		.DEPTH (NUM_WORKERS)
	) u_counts (
		.clk   (clk),
		.we    (cmd.upd),
		.waddr (tgt_q),
		.wdata (wr_data),
		.raddr (raddr),
		.rdata (rd_data)
	);

	// two-choice compare, tie goes by the cursor low bit
	always_comb begin
		tie = (cnt1_q == rd_eff);
		if (cnt1_q < rd_eff) begin
			win = p1_q;
		end else if (rd_eff < cnt1_q) begin
			win = p2_q;
		end else begin
			win = cursor_q[0] ? p1_q : p2_q;
		end
	end

	assign step = (cmd.pick && two_pick) || cmd.rd2 || (cmd.cmp && tie);

	// saturating count update
	always_comb begin
		if (kind_q == KIND_SCHED) begin
			wr_data = (rd_eff == COUNT_MAX) ? rd_eff : rd_eff + COUNT_BITS'(1);
		end else begin
			wr_data = (rd_eff == '0) ? rd_eff : rd_eff - COUNT_BITS'(1);
		end
	end

	assign sts.route_sched = (kind_q == KIND_SCHED) && started_q;
	assign sts.route_take  = (kind_q == KIND_TAKE) && take_ok;
	assign sts.two_pick    = two_pick;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wcount_q  <= CFG_W'(1);
			czero_q   <= 1'b0;
			started_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_WORKER_COUNT: wcount_q  <= cfg_wdata;
				CFG_CALLER_ZERO:  czero_q   <= cfg_wdata[0];
				CFG_STARTED:      started_q <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	// input capture
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			kind_q     <= kind;
			tid_q      <= thread_id;
			widx_q     <= worker_sel;
			from_q     <= from_worker;
			from_vld_q <= from_worker_valid;
			cross_q    <= allow_cross;
			cact_q     <= caller_worker_active;
		end
	end

	// affinity compare, one lane per worker
	always_ff @(posedge clk) begin
		for (int i = 0; i < NUM_WORKERS; i++) begin
			match_q[i] <= (ids_q[i] == tid_q) && (i < 32'(wc)) && (tid_q != '1);
		end
	end

	// bound thread ids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_WORKERS; i++) begin
				ids_q[i] <= '1;
			end
		end else if (cmd.ack && (kind_q == KIND_BIND) && bind_ok) begin
			ids_q[WIX'(widx_q)] <= tid_q;
		end
	end

	// count entry valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_vld_q <= '0;
			rd_vld_q  <= 1'b0;
		end else begin
			rd_vld_q <= cnt_vld_q[raddr];
			if (cmd.upd) begin
				cnt_vld_q[tgt_q] <= 1'b1;
			end
		end
	end

	// pick cursor with a running residue for every range size
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
			for (int k = 2; k <= 15; k++) begin
				res_q[k] <= '0;
			end
		end else if (step) begin
			cursor_q <= cursor_q + CURSOR_W'(1);
			for (int k = 2; k <= 15; k++) begin
				if (wrap || (res_q[k] == WSEL_W'(k - 1))) begin
					res_q[k] <= '0;
				end else begin
					res_q[k] <= res_q[k] + WSEL_W'(1);
				end
			end
		end
	end

	// target selection
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			tgt_q   <= WIX'(worker_sel);
			local_q <= 1'b0;
		end else if (cmd.pick) begin
			p1_q <= p1;
			p2_q <= p2;
			if (!two_pick) begin
				tgt_q   <= WIX'(direct_tgt);
				local_q <= direct_local;
			end
		end else if (cmd.rd2) begin
			cnt1_q <= rd_eff;
		end else if (cmd.cmp) begin
			tgt_q   <= WIX'(win);
			local_q <= 1'b0;
		end
	end

	// result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= cmd.upd || cmd.ack;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.upd) begin
			if (kind_q == KIND_SCHED) begin
				dest_worker   <= 3'(tgt_q);
				status        <= STAT_DISPATCHED;
				local_enqueue <= local_q;
			end else begin
				dest_worker   <= '0;
				status        <= STAT_ACKED;
				local_enqueue <= 1'b0;
			end
		end else if (cmd.ack) begin
			dest_worker   <= '0;
			status        <= (kind_q == KIND_SCHED) ? STAT_DEFERRED : STAT_ACKED;
			local_enqueue <= 1'b0;
		end
	end

endmodule

// ===== rtl/two_choice_worker_dispatcher.sv =====
`timescale 1ns / 1ps

// Two-choice worker dispatcher.
// Commands enter on start while busy is low; the item fields are sampled at
// that edge. One result per command comes back on dest_worker, status and
// local_enqueue, marked by a one-cycle done strobe. The receiver cannot stall:
// results are shown for exactly one cycle, and the next command may be given
// in the cycle that done is high. From accept to done, a schedule with an
// affinity hit, own-queue post or single candidate runs decode, pick, read
// and update; a two-candidate pick adds a second count-store read and a
// compare; a take runs decode, read and update; bind, deferred schedule and
// unknown kinds run decode and acknowledge. The count store has one read
// port, which sets the sequence. One command is worked on at a time.
// Configuration is written through cfg_we, cfg_index and cfg_wdata; the user
// must do so only while the block is idle; the block does not enforce it.
// Reset clears the counts (through per-entry valid bits), unbinds all
// thread ids, zeroes the cursor and loads the register defaults at once.
module two_choice_worker_dispatcher import tcwd_pkg::*; #(
	parameter int NUM_WORKERS = NUM_WORKERS_DEF,
	parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [1:0]              cfg_index,
	input  logic [CFG_W-1:0]        cfg_wdata,
	input  logic                    start,
	output logic                    busy,
	input  logic [1:0]              kind,
	input  logic signed [TID_W-1:0] thread_id,
	input  logic [2:0]              worker_sel,
	input  logic [2:0]              from_worker,
	input  logic                    from_worker_valid,
	input  logic                    allow_cross,
	input  logic                    caller_worker_active,
	output logic                    done,
	output logic [2:0]              dest_worker,
	output logic [1:0]              status,
	output logic                    local_enqueue
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	tcwd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	tcwd_datapath #(
		.NUM_WORKERS (NUM_WORKERS),
		.COUNT_BITS  (COUNT_BITS)
	) u_datapath (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cmd                  (cmd),
		.sts                  (sts),
		.cfg_we               (cfg_we),
		.cfg_index            (cfg_index),
		.cfg_wdata            (cfg_wdata),
		.kind                 (kind),
		.thread_id            (thread_id),
		.worker_sel           (worker_sel),
		.from_worker          (from_worker),
		.from_worker_valid    (from_worker_valid),
		.allow_cross          (allow_cross),
		.caller_worker_active (caller_worker_active),
		.done                 (done),
		.dest_worker          (dest_worker),
		.status               (status),
		.local_enqueue        (local_enqueue)
	);

	// an accepted command always makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted command did not raise busy");

	// the result strobe only follows a finished command
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy && $past(busy))
		else $error("done outside command completion");

	// only a dispatched task names a worker or a local post
	a_nondispatch_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status != STAT_DISPATCHED) |-> (dest_worker == 3'd0) && !local_enqueue)
		else $error("non-dispatch result carries a target");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb import tcwd_pkg::*; ();

	localparam int NW = NUM_WORKERS_DEF;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int PRINT_CAP = 40;
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam logic [1:0] CFG_UNUSED = 2'd3;
	localparam logic [31:0] NO_THREAD = 32'hFFFF_FFFF;
	localparam logic [31:0] TOP_THREAD = 32'h7FFF_FFFF;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] tid;
		logic [2:0]  widx;
		logic [2:0]  from;
		logic        fvalid;
		logic        xpost;
		logic        cactive;
	} work_item_t;

	typedef struct packed {
		logic [2:0] target;
		logic [1:0] stat;
		logic       own_q;
	} dispatch_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_wdata = '0;
	logic start = 1'b0;
	logic busy;
	logic [1:0] kind = '0;
	logic signed [TID_W-1:0] thread_id = '0;
	logic [2:0] worker_sel = '0;
	logic [2:0] from_worker = '0;
	logic from_worker_valid = 1'b0;
	logic allow_cross = 1'b0;
	logic caller_worker_active = 1'b0;
	logic done;
	logic [2:0] dest_worker;
	logic [1:0] status;
	logic local_enqueue;

	two_choice_worker_dispatcher dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_we              (cfg_we),
		.cfg_index           (cfg_index),
		.cfg_wdata           (cfg_wdata),
		.start               (start),
		.busy                (busy),
		.kind                (kind),
		.thread_id           (thread_id),
		.worker_sel          (worker_sel),
		.from_worker         (from_worker),
		.from_worker_valid   (from_worker_valid),
		.allow_cross         (allow_cross),
		.caller_worker_active(caller_worker_active),
		.done                (done),
		.dest_worker         (dest_worker),
		.status              (status),
		.local_enqueue       (local_enqueue)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	work_item_t    pending_items[$];
	dispatch_res_t expected_results[$];
	int            mismatches = 0;
	int            quiet = 0;
	int            idle_pct = 0;
	bit            took = 1'b0;

	// shadow of the dispatcher state and registers
	logic [31:0] queued_model[NW];
	logic [31:0] bound_model[NW];
	logic [31:0] cursor_model;
	logic [3:0]  wc_model;
	logic        cz_model;
	logic        started_model;

	function automatic logic [31:0] workers_in_use();
		if (wc_model == 0)
			return 1;
		if (wc_model > NW)
			return NW;
		return 32'(wc_model);
	endfunction

	// less loaded of two cursor-drawn candidates, tie by cursor low bit
	function automatic logic [31:0] pick_two(logic [31:0] wc, logic active);
		logic [31:0] base, span, p1, p2;
		logic tie_odd;
		base = 0;
		span = wc;
		if (cz_model && wc > 1 && !active) begin
			base = 1;
			span = wc - 1;
		end
		if (span <= 1)
			return base;
		p1 = base + (cursor_model % span);
		cursor_model++;
		p2 = base + (cursor_model % span);
		cursor_model++;
		if (p1 == p2)
			p2 = base + ((p2 - base + 1) % span);
		if (queued_model[p1] < queued_model[p2])
			return p1;
		if (queued_model[p2] < queued_model[p1])
			return p2;
		tie_odd = cursor_model[0];
		cursor_model++;
		return tie_odd ? p1 : p2;
	endfunction

	function automatic dispatch_res_t dispatch_predict(work_item_t it);
		dispatch_res_t r;
		logic [31:0] wc, tgt;
		logic own_ok, hit;
		int i;
		r.target = '0;
		r.stat = STAT_ACKED;
		r.own_q = 1'b0;
		if (it.kind == KIND_SCHED) begin
			if (!started_model) begin
				r.stat = STAT_DEFERRED;
			end else begin
				wc = workers_in_use();
				own_ok = it.fvalid && (it.from < wc);
				hit = 1'b0;
				tgt = 0;
				// affinity search, lowest worker first
				if (it.tid != NO_THREAD) begin
					for (i = 0; i < NW; i++) begin
						if (!hit && i < wc && bound_model[i] == it.tid) begin
							tgt = i;
							hit = 1'b1;
						end
					end
				end
				if (!hit)
					tgt = own_ok ? 32'(it.from) : pick_two(wc, it.cactive);
				if (own_ok && (tgt == it.from || !it.xpost)) begin
					tgt = it.from;
					r.own_q = 1'b1;
				end
				if (queued_model[tgt] != '1)
					queued_model[tgt]++;
				r.stat = STAT_DISPATCHED;
				r.target = tgt[2:0];
			end
		end else if (it.kind == KIND_TAKE) begin
			if (queued_model[it.widx] != 0)
				queued_model[it.widx]--;
		end else if (it.kind == KIND_BIND) begin
			bound_model[it.widx] = it.tid;
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		mismatches++;
		if (mismatches <= PRINT_CAP)
			$display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
	endtask

	// driver: next item at the falling edge once the last one was taken
	always @(negedge clk) begin
		work_item_t nxt;
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!start || took) begin
			if (pending_items.size() != 0 && $urandom_range(99) >= idle_pct) begin
				nxt = pending_items[0];
				pending_items.delete(0);
				start <= 1'b1;
				kind <= nxt.kind;
				thread_id <= nxt.tid;
				worker_sel <= nxt.widx;
				from_worker <= nxt.from;
				from_worker_valid <= nxt.fvalid;
				allow_cross <= nxt.xpost;
				caller_worker_active <= nxt.cactive;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: check results, then predict any item accepted at this edge
	always @(posedge clk) begin
		dispatch_res_t want;
		work_item_t seen;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				report_mismatch("result with no request pending", dest_worker, 0);
			end else begin
				want = expected_results[0];
				expected_results.delete(0);
				if (dest_worker !== want.target)
					report_mismatch("dest_worker", dest_worker, want.target);
				if (status !== want.stat)
					report_mismatch("status", status, want.stat);
				if (local_enqueue !== want.own_q)
					report_mismatch("local_enqueue", local_enqueue, want.own_q);
			end
		end
		took = arst_n && start && !busy;
		if (took) begin
			seen.kind = kind;
			seen.tid = thread_id;
			seen.widx = worker_sel;
			seen.from = from_worker;
			seen.fvalid = from_worker_valid;
			seen.xpost = allow_cross;
			seen.cactive = caller_worker_active;
			expected_results.insert(expected_results.size(), dispatch_predict(seen));
		end
		quiet = (took || (arst_n && done)) ? 0 : quiet + 1;
	end

	// watchdog on cycles with no transfer
	initial begin
		wait (quiet >= WATCHDOG_LIMIT);
		$display("two_choice_worker_dispatcher: mismatch");
		$finish;
	end

	task automatic push(logic [1:0] k, logic [31:0] tid, logic [2:0] widx,
			logic [2:0] from, logic fv, logic cr, logic act);
		work_item_t it;
		it = '{kind: k, tid: tid, widx: widx, from: from, fvalid: fv, xpost: cr,
			cactive: act};
		pending_items.insert(pending_items.size(), it);
	endtask

	// register write while idle, shadow updated alongside
	task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			CFG_WORKER_COUNT: wc_model = val;
			CFG_CALLER_ZERO: cz_model = val[0];
			CFG_STARTED: started_model = val[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// wait for every queued item and result, then let the block go quiet
	task automatic settle();
		while (pending_items.size() != 0 || start || expected_results.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	function automatic logic [31:0] pool_tid();
		return ($urandom_range(8) == 8) ? TOP_THREAD : 32'($urandom_range(7));
	endfunction

	function automatic work_item_t rand_item();
		work_item_t it;
		int sel, pick;
		sel = $urandom_range(99);
		pick = $urandom_range(9);
		it.widx = 3'($urandom_range(7));
		it.from = 3'($urandom_range(7));
		it.fvalid = 1'($urandom_range(1));
		it.xpost = 1'($urandom_range(1));
		it.cactive = 1'($urandom_range(1));
		if (sel < 55) begin
			it.kind = KIND_SCHED;
			it.tid = (pick < 4) ? NO_THREAD : (pick < 8) ? pool_tid() :
				($urandom() & TOP_THREAD);
		end else if (sel < 80) begin
			it.kind = KIND_TAKE;
			it.tid = $urandom() & TOP_THREAD;
		end else if (sel < 95) begin
			it.kind = KIND_BIND;
			it.tid = (pick == 0) ? NO_THREAD : (pick < 8) ? pool_tid() :
				($urandom() & TOP_THREAD);
		end else begin
			it.kind = KIND_UNUSED;
			it.tid = $urandom();
		end
		return it;
	endfunction

	initial begin
		int ph, n;
		int idle_plan[6];
		idle_plan = '{0, 50, 0, 31, 50, 0};
		for (int i = 0; i < NW; i++) begin
			queued_model[i] = '0;
			bound_model[i] = NO_THREAD;
		end
		cursor_model = '0;
		wc_model = 4'd1;
		cz_model = 1'b0;
		started_model = 1'b0;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// not started yet: schedules are deferred, other kinds still act
		push(KIND_SCHED, NO_THREAD, 0, 0, 0, 0, 0);
		push(KIND_SCHED, 32'd5, 0, 0, 1, 1, 1);
		push(KIND_BIND, 32'd0, 0, 0, 0, 0, 0);
		push(KIND_TAKE, 32'd0, 0, 0, 0, 0, 0);
		settle();

		write_reg(CFG_STARTED, 4'd1);
		write_reg(CFG_WORKER_COUNT, 4'd8);
		write_reg(CFG_CALLER_ZERO, 4'd0);
		// affinity hits, own-queue posts, two-choice picks, take at zero
		push(KIND_BIND, TOP_THREAD, 7, 0, 0, 0, 0);
		push(KIND_SCHED, TOP_THREAD, 0, 0, 0, 0, 0);
		push(KIND_SCHED, 32'd0, 0, 3, 1, 0, 1);
		push(KIND_SCHED, 32'd0, 0, 3, 1, 1, 1);
		push(KIND_SCHED, NO_THREAD, 0, 0, 0, 0, 0);
		push(KIND_SCHED, NO_THREAD, 0, 0, 0, 0, 1);
		push(KIND_SCHED, NO_THREAD, 0, 0, 0, 1, 0);
		push(KIND_SCHED, 32'd9, 0, 7, 1, 1, 1);
		push(KIND_TAKE, 32'd0, 7, 0, 0, 0, 0);
		push(KIND_TAKE, 32'd0, 7, 0, 0, 0, 0);
		push(KIND_TAKE, 32'd0, 7, 0, 0, 0, 0);
		push(KIND_UNUSED, NO_THREAD, 7, 7, 1, 1, 1);
		push(KIND_BIND, NO_THREAD, 0, 0, 0, 0, 0);
		push(KIND_SCHED, NO_THREAD, 0, 0, 0, 0, 0);
		settle();

		// zero workers acts as one; requester beyond range is not a worker
		write_reg(CFG_WORKER_COUNT, 4'd0);
		write_reg(CFG_CALLER_ZERO, 4'd1);
		push(KIND_SCHED, NO_THREAD, 0, 0, 0, 0, 0);
		push(KIND_SCHED, NO_THREAD, 0, 1, 1, 0, 1);
		push(KIND_SCHED, TOP_THREAD, 0, 0, 0, 0, 0);
		settle();

		// caller worker zero inactive skips worker zero
		write_reg(CFG_WORKER_COUNT, 4'd3);
		write_reg(CFG_CALLER_ZERO, 4'hF);
		write_reg(CFG_UNUSED, 4'd5);
		push(KIND_SCHED, NO_THREAD, 0, 0, 0, 0, 0);
		push(KIND_SCHED, NO_THREAD, 0, 0, 0, 1, 0);
		push(KIND_SCHED, NO_THREAD, 0, 0, 0, 0, 1);
		push(KIND_SCHED, TOP_THREAD, 0, 2, 1, 0, 0);
		settle();

		// count above the worker limit clamps to all workers
		write_reg(CFG_WORKER_COUNT, 4'd15);
		push(KIND_SCHED, TOP_THREAD, 0, 7, 1, 1, 1);
		push(KIND_SCHED, TOP_THREAD, 0, 7, 1, 0, 0);
		settle();

		// random phases under varied settings and sender idling
		for (ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin
					write_reg(CFG_WORKER_COUNT, 4'd8);
					write_reg(CFG_CALLER_ZERO, 4'd0);
				end
				1: begin
					write_reg(CFG_WORKER_COUNT, 4'd1);
					write_reg(CFG_CALLER_ZERO, 4'd1);
				end
				2: begin
					write_reg(CFG_WORKER_COUNT, 4'd3);
					write_reg(CFG_CALLER_ZERO, 4'd1);
				end
				4: begin
					write_reg(CFG_WORKER_COUNT, 4'd15);
					write_reg(CFG_CALLER_ZERO, 4'd1);
				end
				default: begin
					write_reg(CFG_WORKER_COUNT, 4'($urandom_range(15)));
					write_reg(CFG_CALLER_ZERO, 4'($urandom_range(1)));
				end
			endcase
			write_reg(CFG_STARTED, (ph == 5 && $urandom_range(3) == 0) ? 4'd0 : 4'd1);
			idle_pct = idle_plan[ph];
			for (n = 0; n < 80; n++)
				pending_items.insert(pending_items.size(), rand_item());
			settle();
		end

		if (mismatches == 0)
			$display("two_choice_worker_dispatcher: match");
		else
			$display("two_choice_worker_dispatcher: mismatch");
		$finish;
	end

endmodule

// ===== two_choice_worker_dispatcher.f =====
rtl/tcwd_pkg.sv
rtl/tcwd_ram.sv
rtl/tcwd_ctrl.sv
rtl/tcwd_datapath.sv
rtl/two_choice_worker_dispatcher.sv
test/tb.sv
